FILE: sv/multi_mode_vector_distance_unit_assert.svh
// Assertion macros for the vector distance unit.
`ifndef MULTI_MODE_VECTOR_DISTANCE_UNIT_ASSERT_SVH
`define MULTI_MODE_VECTOR_DISTANCE_UNIT_ASSERT_SVH
// same-cycle implication
`define MVD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: sv/mvd_pkg.sv
// Shared constants, types and codes of the vector distance unit.
package mvd_pkg;

  localparam int unsigned FractionBits = 24;
  localparam int unsigned ElemW        = 32;
  localparam int unsigned OutW         = 48;
  localparam int unsigned AccW         = 64;
  localparam int unsigned ModeW        = 3;
  localparam int unsigned EpsW         = 16;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned OpW          = ElemW + 1;
  localparam int unsigned DenW         = ElemW + 2;
  localparam int unsigned MagW         = ElemW + 1;
  localparam int unsigned MulW         = 2 * OpW;
  localparam int unsigned MantW        = 32;
  localparam int unsigned NormW        = MantW + 2;
  localparam int unsigned LogIntW      = 7;
  localparam int unsigned LogW         = FractionBits + LogIntW;
  localparam int unsigned DivSteps     = AccW;
  localparam int unsigned SqrtSteps    = 47;
  localparam int unsigned RadW         = 2 * SqrtSteps;
  localparam int unsigned CntW         = 7;

  localparam logic [EpsW-1:0]  EpsReset  = EpsW'(17);
  localparam logic [ModeW-1:0] ModeReset = '0;

  localparam logic signed [AccW-1:0] AccLim    = {2'b01, {(AccW-2){1'b0}}};
  localparam logic signed [AccW-1:0] AccLimNeg = {2'b11, {(AccW-2){1'b0}}};
  localparam logic signed [AccW-1:0] FxOne     = AccW'(1) <<< FractionBits;
  localparam logic signed [AccW-1:0] OutMaxW   = (AccW'(1) <<< (OutW-1)) - AccW'(1);
  localparam logic signed [AccW-1:0] OutMinW   = -(AccW'(1) <<< (OutW-1));

  typedef enum logic [ModeW-1:0] {
    MODE_COSINE = 3'd0,
    MODE_L1     = 3'd1,
    MODE_L2     = 3'd2,
    MODE_CHI2   = 3'd3,
    MODE_JS     = 3'd4
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE = 1'b0,
    CFG_EPS  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_SUM,
    PH_A,
    PH_B
  } js_phase_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_COS_MUL,
    ST_COS_ACC,
    ST_L1,
    ST_L2_MUL,
    ST_L2_ACC,
    ST_CHI_MUL,
    ST_CHI_DIV,
    ST_CHI_ACC,
    ST_JS_COMP,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_LOG_END,
    ST_JS_MUL_HI,
    ST_JS_MUL_LO,
    ST_JS_ACC,
    ST_FINISH,
    ST_SQRT,
    ST_SQRT_END,
    ST_OUT
  } eng_state_e;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [EpsW-1:0]  eps;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    logic signed [OutW-1:0] value;
  } res_t;

endpackage

FILE: sv/multi_mode_vector_distance_unit.sv
// Top level of the vector distance unit: config registers, engine, output register.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, x/y/last_element_i    | input
//  out     | out_valid_o/out_ready_i, distance_value_o    | output
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i/data_i  | input
//
// Per pair: Chi2 runs a 64-step divider, JS up to three log2 runs on the multiplier.
// A last pair in L2 also runs the square root.
// Reset clears the accumulator and loads mode 0 and epsilon 17.
// in_ready_o is low while a pair is in the engine; a result waits in the
// engine until the output register is free, while that register holds for out_ready_i.
`include "multi_mode_vector_distance_unit_assert.svh"
module multi_mode_vector_distance_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [mvd_pkg::ElemW-1:0]   x_element_i,
  input  logic signed [mvd_pkg::ElemW-1:0]   y_element_i,
  input  logic                               last_element_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [mvd_pkg::OutW-1:0]    distance_value_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [mvd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mvd_pkg::EpsW-1:0]           cfg_data_i
);
  import mvd_pkg::*;

  cfg_t cfg_q;
  res_t eng_res;
  logic eng_idle, start, res_take;
  logic out_valid_q;
  logic signed [OutW-1:0] out_data_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = eng_idle;
  assign start       = in_valid_i && in_ready_o;
  assign res_take    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode <= ModeReset;
      cfg_q.eps  <= EpsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODE: cfg_q.mode <= cfg_data_i[ModeW-1:0];
        CFG_EPS:  cfg_q.eps  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  mvd_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start),
    .x_i        (x_element_i),
    .y_i        (y_element_i),
    .last_i     (last_element_i),
    .idle_o     (eng_idle),
    .res_take_i (res_take),
    .res_o      (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_res.valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_res.valid && res_take) begin
      out_data_q <= eng_res.value;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign distance_value_o = out_data_q;

  `MVD_ASSERT_NEXT(a_busy_after_start, clk_i, rst_ni, start, !in_ready_o, "engine idle after start")
  `MVD_ASSERT_NEXT(a_res_held, clk_i, rst_ni, eng_res.valid && !res_take, eng_res.valid && $stable(eng_res.value), "engine result dropped")
  `MVD_ASSERT_NEXT(a_res_loaded, clk_i, rst_ni, eng_res.valid && res_take, out_valid_o, "result not loaded")
  `MVD_ASSERT_SAME(a_res_not_idle, clk_i, rst_ni, eng_res.valid, !in_ready_o, "ready while result pending")

endmodule

FILE: sv/mvd_engine.sv
// Sequenced datapath: shared multiplier, bit-serial divider, log2 and square root.
module mvd_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  mvd_pkg::cfg_t                       cfg_i,
  input  logic                                start_i,
  input  logic signed [mvd_pkg::ElemW-1:0]    x_i,
  input  logic signed [mvd_pkg::ElemW-1:0]    y_i,
  input  logic                                last_i,
  output logic                                idle_o,
  input  logic                                res_take_i,
  output mvd_pkg::res_t                       res_o
);
  import mvd_pkg::*;

  eng_state_e state_q, state_d;
  js_phase_e  phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [AccW-1:0] acc_q, acc_d;

  logic signed [ElemW-1:0] x_q, y_q;
  logic last_q;
  logic signed [MulW-1:0] prod_q, prod_d;
  logic [AccW-1:0] div_q, div_d;
  logic [MagW-1:0] drem_q, drem_d;
  logic [NormW-1:0] m_q, m_d;
  logic signed [LogIntW-1:0] n_q, n_d;
  logic [FractionBits-1:0] frac_q, frac_d;
  logic signed [LogW-1:0] ls_q, ls_d;
  logic signed [LogW:0] d_q, d_d;
  logic [AccW-1:0] jsp_q, jsp_d;
  logic [RadW-1:0] rad_q, rad_d;
  logic [SqrtSteps:0] srem_q, srem_d;
  logic [SqrtSteps-1:0] root_q, root_d;
  logic signed [OutW-1:0] res_q, res_d;

  logic signed [OpW-1:0]  a_w, b_w, u_w, diff_w;
  logic signed [DenW-1:0] s_w;
  logic [MagW-1:0]        s_mag;
  logic [ElemW-1:0]       a_mag, b_mag, diff_mag;
  logic                   chi_neg, u_pos, s_pos;
  logic [LogW-1:0]        d_mag;
  logic signed [LogIntW-1:0] n_off;
  logic signed [LogW-1:0] l_w;
  logic signed [OpW-1:0]  mul_a, mul_b;
  logic signed [MulW-1:0] mul_p;
  logic                   p_top;
  logic signed [AccW-1:0] term_w, acc_sum, acc_upd, quo_lim, fin_w;
  logic [AccW-1:0]        js_p;
  logic [MagW:0]          rsh;
  logic                   div_ge;
  logic [SqrtSteps+2:0]   ssh;
  logic [SqrtSteps+1:0]   trial;
  logic                   sq_ge;

  function automatic logic signed [AccW-1:0] sat_lim(input logic signed [AccW-1:0] v);
    if (v > AccLim) begin
      return AccLim;
    end else if (v < AccLimNeg) begin
      return AccLimNeg;
    end
    return v;
  endfunction

  function automatic logic signed [OutW-1:0] sat_out(input logic signed [AccW-1:0] v);
    if (v > OutMaxW) begin
      return OutW'(OutMaxW);
    end else if (v < OutMinW) begin
      return OutW'(OutMinW);
    end
    return OutW'(v);
  endfunction

  assign a_w      = OpW'(x_q) + $signed({{(OpW-EpsW){1'b0}}, cfg_i.eps});
  assign b_w      = OpW'(y_q) + $signed({{(OpW-EpsW){1'b0}}, cfg_i.eps});
  assign s_w      = DenW'(a_w) + DenW'(b_w);
  assign s_mag    = s_w[DenW-1] ? MagW'(-s_w) : MagW'(s_w);
  assign a_mag    = a_w[OpW-1] ? ElemW'(-a_w) : ElemW'(a_w);
  assign b_mag    = b_w[OpW-1] ? ElemW'(-b_w) : ElemW'(b_w);
  assign diff_w   = OpW'(x_q) - OpW'(y_q);
  assign diff_mag = diff_w[OpW-1] ? ElemW'(-diff_w) : ElemW'(diff_w);
  assign chi_neg  = (a_w[OpW-1] ^ b_w[OpW-1]) ^ s_w[DenW-1];
  assign s_pos    = !s_w[DenW-1] && (s_w != '0);
  assign u_w      = (phase_q == PH_B) ? b_w : a_w;
  assign u_pos    = !u_w[OpW-1] && (u_w != '0);
  assign d_mag    = d_q[LogW] ? LogW'(-d_q) : LogW'(d_q);
  assign n_off    = n_q - LogIntW'(FractionBits);
  assign l_w      = $signed({n_off, frac_q});

  assign mul_p = mul_a * mul_b;
  assign p_top = mul_p[2*MantW-1];

  assign acc_sum = acc_q + sat_lim(term_w);
  assign acc_upd = sat_lim(acc_sum);
  assign quo_lim = (div_q > $unsigned(AccLim)) ? AccLim : $signed(div_q);
  assign js_p    = jsp_q + AccW'(prod_q >>> FractionBits);

  assign rsh    = {drem_q, div_q[AccW-1]};
  assign div_ge = rsh >= {1'b0, s_mag};
  assign ssh    = {srem_q, rad_q[RadW-1:RadW-2]};
  assign trial  = {root_q, 2'b01};
  assign sq_ge  = ssh >= {1'b0, trial};

  always_comb begin
    case (cfg_i.mode)
      MODE_COSINE, MODE_CHI2: fin_w = FxOne - acc_q;
      MODE_L1:                fin_w = acc_q;
      MODE_JS:                fin_w = FxOne - (acc_q >>> 1);
      default:                fin_w = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    prod_d  = prod_q;
    div_d   = div_q;
    drem_d  = drem_q;
    m_d     = m_q;
    n_d     = n_q;
    frac_d  = frac_q;
    ls_d    = ls_q;
    d_d     = d_q;
    jsp_d   = jsp_q;
    rad_d   = rad_q;
    srem_d  = srem_q;
    root_d  = root_q;
    res_d   = res_q;
    mul_a   = '0;
    mul_b   = '0;
    term_w  = '0;
    res_o.valid = 1'b0;
    res_o.value = res_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (cfg_i.mode)
          MODE_COSINE: state_d = ST_COS_MUL;
          MODE_L1:     state_d = ST_L1;
          MODE_L2:     state_d = ST_L2_MUL;
          MODE_CHI2:   state_d = s_w != '0 ? ST_CHI_MUL : ST_FINISH;
          MODE_JS: begin
            phase_d = PH_SUM;
            if (s_pos) begin
              m_d     = NormW'(s_w);
              n_d     = LogIntW'(MantW - 1);
              state_d = ST_LOG_NORM;
            end else begin
              state_d = ST_FINISH;
            end
          end
          default:     state_d = ST_FINISH;
        endcase
      end
      ST_COS_MUL: begin
        mul_a   = OpW'(x_q);
        mul_b   = OpW'(y_q);
        prod_d  = mul_p;
        state_d = ST_COS_ACC;
      end
      ST_L2_MUL: begin
        mul_a   = $signed({1'b0, diff_mag});
        mul_b   = $signed({1'b0, diff_mag});
        prod_d  = mul_p;
        state_d = ST_L2_ACC;
      end
      ST_COS_ACC, ST_L2_ACC: begin
        term_w  = AccW'(prod_q >>> FractionBits);
        acc_d   = acc_upd;
        state_d = ST_FINISH;
      end
      ST_L1: begin
        term_w  = AccW'($signed({1'b0, diff_mag}));
        acc_d   = acc_upd;
        state_d = ST_FINISH;
      end
      ST_CHI_MUL: begin
        mul_a   = $signed({1'b0, a_mag});
        mul_b   = $signed({1'b0, b_mag});
        div_d   = {mul_p[AccW-2:0], 1'b0};
        drem_d  = '0;
        cnt_d   = CntW'(DivSteps);
        state_d = ST_CHI_DIV;
      end
      ST_CHI_DIV: begin
        drem_d = div_ge ? MagW'(rsh - {1'b0, s_mag}) : rsh[MagW-1:0];
        div_d  = {div_q[AccW-2:0], div_ge};
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_CHI_ACC;
        end
      end
      ST_CHI_ACC: begin
        term_w  = chi_neg ? -quo_lim : quo_lim;
        acc_d   = acc_upd;
        state_d = ST_FINISH;
      end
      ST_JS_COMP: begin
        if (u_pos) begin
          m_d     = NormW'(u_w);
          n_d     = LogIntW'(MantW - 1);
          state_d = ST_LOG_NORM;
        end else if (phase_q == PH_A) begin
          phase_d = PH_B;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_LOG_NORM: begin
        if (m_q[NormW-1:MantW] != '0) begin
          m_d = m_q >> 1;
          n_d = n_q + LogIntW'(1);
        end else if (!m_q[MantW-1]) begin
          m_d = m_q << 1;
          n_d = n_q - LogIntW'(1);
        end else begin
          frac_d  = '0;
          cnt_d   = CntW'(FractionBits);
          state_d = ST_LOG_SQ;
        end
      end
      ST_LOG_SQ: begin
        mul_a  = $signed({1'b0, m_q[MantW-1:0]});
        mul_b  = $signed({1'b0, m_q[MantW-1:0]});
        m_d    = NormW'(p_top ? mul_p[2*MantW-1:MantW] : mul_p[2*MantW-2:MantW-1]);
        frac_d = {frac_q[FractionBits-2:0], p_top};
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_LOG_END;
        end
      end
      ST_LOG_END: begin
        if (phase_q == PH_SUM) begin
          ls_d    = l_w;
          phase_d = PH_A;
          state_d = ST_JS_COMP;
        end else begin
          d_d     = (LogW+1)'(ls_q) - (LogW+1)'(l_w);
          state_d = ST_JS_MUL_HI;
        end
      end
      ST_JS_MUL_HI: begin
        mul_a   = u_w;
        mul_b   = $signed(OpW'(d_mag[LogW-1:FractionBits]));
        prod_d  = mul_p;
        state_d = ST_JS_MUL_LO;
      end
      ST_JS_MUL_LO: begin
        mul_a   = u_w;
        mul_b   = $signed(OpW'(d_mag[FractionBits-1:0]));
        jsp_d   = prod_q[AccW-1:0];
        prod_d  = mul_p;
        state_d = ST_JS_ACC;
      end
      ST_JS_ACC: begin
        term_w = d_q[LogW] ? -$signed(js_p) : $signed(js_p);
        acc_d  = acc_upd;
        if (phase_q == PH_A) begin
          phase_d = PH_B;
          state_d = ST_JS_COMP;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!last_q) begin
          state_d = ST_IDLE;
        end else if ((cfg_i.mode == MODE_L2) && !acc_q[AccW-1]) begin
          rad_d   = RadW'(acc_q[AccW-2:0]) << FractionBits;
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = CntW'(SqrtSteps);
          state_d = ST_SQRT;
        end else begin
          res_d   = sat_out(fin_w);
          state_d = ST_OUT;
        end
      end
      ST_SQRT: begin
        srem_d = sq_ge ? (SqrtSteps+1)'(ssh - {1'b0, trial}) : ssh[SqrtSteps:0];
        root_d = {root_q[SqrtSteps-2:0], sq_ge};
        rad_d  = rad_q << 2;
        cnt_d  = cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          state_d = ST_SQRT_END;
        end
      end
      ST_SQRT_END: begin
        res_d   = sat_out(AccW'(root_q));
        state_d = ST_OUT;
      end
      ST_OUT: begin
        res_o.valid = 1'b1;
        if (res_take_i) begin
          acc_d   = '0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_SUM;
      cnt_q   <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= x_i;
      y_q    <= y_i;
      last_q <= last_i;
    end
    prod_q <= prod_d;
    div_q  <= div_d;
    drem_q <= drem_d;
    m_q    <= m_d;
    n_q    <= n_d;
    frac_q <= frac_d;
    ls_q   <= ls_d;
    d_q    <= d_d;
    jsp_q  <= jsp_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    res_q  <= res_d;
  end

endmodule

FILE: bench/tb_multi_mode_vector_distance_unit.sv
// Testbench for the multi-mode vector distance unit: directed and random vectors, scoreboarded.
module tb_multi_mode_vector_distance_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mvd_pkg::*;

  localparam longint SatLim = 64'sh4000_0000_0000_0000;
  localparam longint OutHi  = (64'sd1 <<< 47) - 1;
  localparam longint OutLo  = -(64'sd1 <<< 47);
  localparam int     RandItems = 1150;
  localparam int     DrainCycles = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [ElemW-1:0] x_element_i = '0;
  logic signed [ElemW-1:0] y_element_i = '0;
  logic last_element_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [OutW-1:0] distance_value_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CFG_MODE;
  logic [EpsW-1:0] cfg_data_i = '0;

  multi_mode_vector_distance_unit DUT (.*);

  always #5 clk_i = ~clk_i;

  logic [ModeW-1:0]     pred_mode;
  logic [EpsW-1:0]      pred_eps;
  longint               term_sum;
  logic [OutW-1:0]      expected_distances[$];
  int                   error_count = 0;
  int                   items_sent = 0;
  int                   burst_left = 0;

  task automatic report(string what);
    error_count++;
    $display("%0t ERROR %s", $time, what);
  endtask

  function automatic longint clamp_sat(longint v);
    if (v > SatLim) return SatLim;
    if (v < -SatLim) return -SatLim;
    return v;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint signed_mag(bit neg, longint unsigned m);
    longint s;
    s = (m > longint'(SatLim)) ? SatLim : longint'(m);
    return neg ? -s : s;
  endfunction

  task automatic add_term(longint t);
    term_sum = clamp_sat(term_sum + clamp_sat(t));
  endtask

  function automatic longint log2_fx(longint unsigned v);
    int n;
    longint unsigned m, frac;
    n = 0;
    frac = 0;
    while (n < 63 && (v >> (n + 1)) != 0) n++;
    m = (n >= 31) ? (v >> (n - 31)) : (v << (31 - n));
    for (int i = 0; i < FractionBits; i++) begin
      m = (m * m) >> 31;
      frac = frac << 1;
      if (m >= (64'd1 << 32)) begin
        m = m >> 1;
        frac = frac | 1;
      end
    end
    return (longint'(n) - longint'(FractionBits)) * (64'sd1 <<< FractionBits) + longint'(frac);
  endfunction

  function automatic longint unsigned mul_frac(longint unsigned u, longint unsigned d);
    longint unsigned fmask;
    fmask = (64'd1 << FractionBits) - 1;
    return u * (d >> FractionBits) + ((u * (d & fmask)) >> FractionBits);
  endfunction

  function automatic longint sqrt_fx(longint acc);
    longint unsigned a, rem, root, trial;
    int k;
    bit [1:0] pair;
    a = acc;
    rem = 0;
    root = 0;
    for (int i = 46; i >= 0; i--) begin
      for (int j = 0; j < 2; j++) begin
        k = 2 * i + 1 - j;
        pair[1-j] = (k >= FractionBits && k - FractionBits < 64) ?
                    a[k-FractionBits] : 1'b0;
      end
      rem = (rem << 2) | pair;
      root = root << 1;
      trial = (root << 1) | 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 1;
      end
    end
    return longint'(root);
  endfunction

  task automatic add_js_part(longint u, longint s);
    longint d;
    if (u <= 0 || s <= 0) return;
    d = log2_fx(s) - log2_fx(u);
    add_term(signed_mag(d < 0, mul_frac(u, mag(d))));
  endtask

  task automatic predict_distance(logic signed [ElemW-1:0] xe, logic signed [ElemW-1:0] ye,
                                  logic last);
    longint x, y, a, b, den, res;
    longint unsigned m, num;
    x = xe;
    y = ye;
    a = x + longint'(pred_eps);
    b = y + longint'(pred_eps);
    den = a + b;
    case (pred_mode)
      MODE_COSINE: add_term((x * y) >>> FractionBits);
      MODE_L1:     add_term(longint'(mag(x - y)));
      MODE_L2: begin
        m = mag(x - y);
        add_term(longint'((m * m) >> FractionBits));
      end
      MODE_CHI2: begin
        if (den != 0) begin
          num = 2 * (mag(a) * mag(b));
          add_term(signed_mag(((a < 0) != (b < 0)) != (den < 0), num / mag(den)));
        end
      end
      MODE_JS: begin
        add_js_part(a, den);
        add_js_part(b, den);
      end
      default: ;
    endcase
    if (!last) return;
    case (pred_mode)
      MODE_COSINE, MODE_CHI2: res = FxOne - term_sum;
      MODE_L1:                res = term_sum;
      MODE_L2:                res = (term_sum < 0) ? 0 : sqrt_fx(term_sum);
      MODE_JS:                res = FxOne - (term_sum >>> 1);
      default:                res = 0;
    endcase
    if (res > OutHi) res = OutHi;
    if (res < OutLo) res = OutLo;
    expected_distances.push_back(res[OutW-1:0]);
    term_sum = 0;
  endtask

  task automatic send_pair(logic signed [ElemW-1:0] xe, logic signed [ElemW-1:0] ye,
                           logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    x_element_i <= xe;
    y_element_i <= ye;
    last_element_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_distance(xe, ye, last);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (expected_distances.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [EpsW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MODE) pred_mode = data[ModeW-1:0];
    else pred_eps = data;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [ElemW-1:0] pick_element();
    case ($urandom_range(0, 6))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 32'h0400_0000);
      3:    return -$signed({1'b0, 31'($urandom_range(0, 32'h0200_0000))});
      4:    return $signed(32'($urandom_range(0, 32'h0100_0000)));
      5:    return -$signed(32'(pred_eps)) + $signed(32'($urandom_range(0, 4))) - 2;
      default: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (expected_distances.size() == 0) begin
        report($sformatf("unexpected distance %0d", distance_value_o));
      end else begin
        if (distance_value_o !== expected_distances[0])
          report($sformatf("distance got %0d want %0d", distance_value_o,
                           $signed(expected_distances[0])));
        void'(expected_distances.pop_front());
      end
    end
  end

  int stall_phase = 0;
  always @(posedge clk_i) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 150) out_ready_i <= 1'b1;
    else if (stall_phase < 300) out_ready_i <= ($urandom_range(0, 2) != 0);
    else out_ready_i <= ($urandom_range(0, 9) == 0);
  end

  task automatic test_extremes_all_modes();
    for (int md = 0; md < 8; md++) begin
      write_reg(CFG_MODE, {13'($urandom_range(0, 8191)), 3'(md)});
      send_pair(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
      send_pair(32'sh8000_0000, 32'sh7fff_ffff, 1'b0);
      send_pair(-$signed(32'(pred_eps)), -$signed(32'(pred_eps)), 1'b1);
      wait_idle();
    end
  endtask

  task automatic test_mode_switch_midvector();
    write_reg(CFG_EPS, 16'hffff);
    write_reg(CFG_MODE, EpsW'(MODE_COSINE));
    send_pair(32'sh7fff_ffff, 32'sh8000_0000, 1'b0);
    wait_idle();
    write_reg(CFG_MODE, EpsW'(MODE_L2));
    send_pair(32'sh0000_0000, 32'sh0000_0000, 1'b1);
    wait_idle();
    write_reg(CFG_MODE, EpsW'(MODE_JS));
    send_pair(32'sh0100_0000, 32'shff00_0000, 1'b0);
    send_pair(32'sh0000_0000, 32'sh0000_0000, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_vectors();
    int len;
    while (items_sent < RandItems) begin
      write_reg(CFG_MODE, ($urandom_range(0, 9) == 0) ? 16'($urandom_range(5, 7)) :
                          16'($urandom_range(0, 4)));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_EPS, 16'h0000);
        1: write_reg(CFG_EPS, 16'hffff);
        default: write_reg(CFG_EPS, 16'($urandom));
      endcase
      repeat ($urandom_range(2, 6)) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
          send_pair(pick_element(), pick_element(), i == len - 1);
      end
      wait_idle();
    end
  endtask

  initial begin
    pred_mode = ModeReset;
    pred_eps = EpsReset;
    term_sum = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_pair(32'sh0100_0000, 32'sh0080_0000, 1'b1);
    wait_idle();
    test_extremes_all_modes();
    test_mode_switch_midvector();
    test_random_vectors();
    wait_idle();
    if (error_count == 0) begin
      $display("tb_multi_mode_vector_distance_unit: clean");
    end else begin
      $display("tb_multi_mode_vector_distance_unit: errors");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_multi_mode_vector_distance_unit: errors");
    $finish;
  end

endmodule
